[rtl/core/ost_pkg.sv]
// Shared types and constants for the order status table.
// Holds item kinds, status codes and the record and control structs.
// No dependencies.
package ost_pkg;

    localparam int OST_TABLE_ENTRIES = 64;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_MODIFY = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_TRADE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_NEW       = 2'd0,
        ST_PARTIAL   = 2'd1,
        ST_FILLED    = 2'd2,
        ST_CANCELLED = 2'd3
    } status_t;

    // One stored order, without its key.
    typedef struct packed {
        logic [63:0]        symbol;
        logic               side;
        logic [30:0]        quantity;
        logic [31:0]        price;
        logic signed [31:0] filled;
        status_t            status;
    } rec_t;

    // One result as it leaves the block.
    typedef struct packed {
        logic        found;
        logic        changed;
        logic        table_full;
        logic [63:0] order_id;
        rec_t        rec;
    } res_t;

    // Key search status toward the controller.
    typedef struct packed {
        logic done;
        logic hit_a;
        logic hit_b;
    } scan_flags_t;

    // What the update logic needs to know about the current item.
    typedef struct packed {
        kind_t kind;
        logic  is_user;
        logic  hit_a;
        logic  hit_b;
        logic  full;
    } upd_ctl_t;

    // Write actions decided by the update logic.
    typedef struct packed {
        logic wr_key;
        logic wr_rec;
        logic grow;
    } upd_act_t;

endpackage

[rtl/core/ost_key_scan.sv]
// Key memory and linear key search for the order status table.
// Walks the filled part of the key memory one entry a cycle.
// Depends on ost_pkg.
module ost_key_scan
    import ost_pkg::*;
#(
    parameter int TABLE_ENTRIES = OST_TABLE_ENTRIES,
    localparam int IDX_W = $clog2(TABLE_ENTRIES),
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [63:0]        key_a,
    input  logic [63:0]        key_b,
    input  logic [CNT_W-1:0]   count,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic [63:0]        wr_key,
    output scan_flags_t        flags,
    output logic [IDX_W-1:0]   idx_a,
    output logic [IDX_W-1:0]   idx_b
);

    logic [63:0]      key_mem [TABLE_ENTRIES];
    logic [63:0]      rd_data_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_vld_reg;
    logic             rd_last_reg;
    logic             issuing_reg;
    logic [IDX_W-1:0] addr_reg;
    logic             done_reg;
    logic             hit_a_reg;
    logic             hit_b_reg;
    logic [IDX_W-1:0] idx_a_reg;
    logic [IDX_W-1:0] idx_b_reg;
    logic [63:0]      key_a_reg;
    logic [63:0]      key_b_reg;
    logic             last_addr;

    assign last_addr = (CNT_W'(addr_reg) + CNT_W'(1)) == count;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        rd_data_reg <= key_mem[addr_reg];
        rd_idx_reg  <= addr_reg;
        if (start)
        begin
            key_a_reg <= key_a;
            key_b_reg <= key_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg <= 1'b0;
            addr_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            done_reg    <= 1'b0;
            hit_a_reg   <= 1'b0;
            hit_b_reg   <= 1'b0;
            idx_a_reg   <= '0;
            idx_b_reg   <= '0;
        end
        else
        begin
            rd_vld_reg  <= issuing_reg;
            rd_last_reg <= issuing_reg && last_addr;
            // An empty table needs no walk at all.
            done_reg    <= rd_last_reg || (start && count == '0);
            if (start)
            begin
                hit_a_reg <= 1'b0;
                hit_b_reg <= 1'b0;
                addr_reg  <= '0;
                if (count != '0)
                begin
                    issuing_reg <= 1'b1;
                end
            end
            else if (issuing_reg)
            begin
                if (last_addr)
                begin
                    issuing_reg <= 1'b0;
                end
                else
                begin
                    addr_reg <= addr_reg + IDX_W'(1);
                end
            end
            // Keep the lowest matching entry for each key.
            if (rd_vld_reg)
            begin
                if (!hit_a_reg && rd_data_reg == key_a_reg)
                begin
                    hit_a_reg <= 1'b1;
                    idx_a_reg <= rd_idx_reg;
                end
                if (!hit_b_reg && rd_data_reg == key_b_reg)
                begin
                    hit_b_reg <= 1'b1;
                    idx_b_reg <= rd_idx_reg;
                end
            end
        end
    end

    assign flags.done  = done_reg;
    assign flags.hit_a = hit_a_reg;
    assign flags.hit_b = hit_b_reg;
    assign idx_a       = idx_a_reg;
    assign idx_b       = idx_b_reg;

endmodule

[rtl/core/ost_record_mem.sv]
// Record memory of the order status table: one order record per entry.
// Synchronous write, registered read.
// Depends on ost_pkg.
module ost_record_mem
    import ost_pkg::*;
#(
    parameter int TABLE_ENTRIES = OST_TABLE_ENTRIES,
    localparam int IDX_W = $clog2(TABLE_ENTRIES)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  rec_t             wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output rec_t             rd_data
);

    rec_t rec_mem [TABLE_ENTRIES];
    rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rec_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= rec_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/ost_update.sv]
// Update step of the order status table: new record, write actions and result.
// Purely combinational; works on the record read back from memory.
// Depends on ost_pkg.
module ost_update
    import ost_pkg::*;
(
    input  upd_ctl_t    ctl,
    input  logic [63:0] order_id,
    input  logic [63:0] other_id,
    input  logic [63:0] symbol_code,
    input  logic        side_in,
    input  logic [30:0] quantity_in,
    input  logic [31:0] price_in,
    input  rec_t        rec_old,
    output rec_t        rec_new,
    output upd_act_t    act,
    output res_t        res
);

    logic signed [31:0] old_qty;
    logic signed [31:0] diff;

    assign old_qty = $signed({1'b0, rec_old.quantity});
    assign diff    = old_qty - $signed({1'b0, quantity_in});

    always_comb
    begin
        act     = '0;
        res     = '0;
        rec_new = rec_old;
        case (ctl.kind)
            KIND_ADD:
            begin
                if (ctl.is_user)
                begin
                    if (ctl.hit_a || !ctl.full)
                    begin
                        rec_new.symbol   = symbol_code;
                        rec_new.side     = side_in;
                        rec_new.quantity = quantity_in;
                        rec_new.price    = price_in;
                        rec_new.filled   = '0;
                        rec_new.status   = ST_NEW;
                        act.wr_key       = 1'b1;
                        act.wr_rec       = 1'b1;
                        act.grow         = !ctl.hit_a;
                        res.found        = 1'b1;
                        res.changed      = 1'b1;
                        res.order_id     = order_id;
                        res.rec          = rec_new;
                    end
                    else
                    begin
                        res.table_full = 1'b1;
                    end
                end
            end
            KIND_MODIFY:
            begin
                if (ctl.hit_a)
                begin
                    if (diff >= old_qty)
                    begin
                        rec_new.filled = old_qty;
                        rec_new.status = ST_FILLED;
                    end
                    else
                    begin
                        rec_new.filled = diff;
                        rec_new.status = ST_PARTIAL;
                    end
                    act.wr_rec   = 1'b1;
                    res.found    = 1'b1;
                    res.changed  = 1'b1;
                    res.order_id = order_id;
                    res.rec      = rec_new;
                end
            end
            KIND_REMOVE:
            begin
                if (ctl.hit_a)
                begin
                    if (!(rec_old.status inside {ST_FILLED, ST_CANCELLED}))
                    begin
                        rec_new.status = ST_CANCELLED;
                        act.wr_rec     = 1'b1;
                        res.changed    = 1'b1;
                    end
                    res.found    = 1'b1;
                    res.order_id = order_id;
                    res.rec      = rec_new;
                end
            end
            KIND_TRADE:
            begin
                // The sell-side key wins when both are tracked.
                if (ctl.hit_a || ctl.hit_b)
                begin
                    res.found    = 1'b1;
                    res.order_id = ctl.hit_a ? order_id : other_id;
                    res.rec      = rec_old;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

[rtl/core/order_status_table_unit.sv]
// Top level of the order status table: controller, fill count and result register.
// Instantiates ost_key_scan, ost_record_mem and ost_update; depends on ost_pkg.
//
//  channel  | handshake           | fields
//  ---------+---------------------+-----------------------------------------------
//  item in  | start, busy         | kind, order_id, other_id, is_user_order,
//           |                     | symbol_code, side_in, quantity_in, price_in
//  result   | done (one cycle)    | found, changed, table_full, order_id_out,
//           |                     | symbol_out, side_out, quantity_out, price_out,
//           |                     | filled_out, status_out
//
// An item is taken when start is high and busy is low. It then stays busy while the key
// memory is walked over the filled entries, one entry a cycle (no walk on an empty
// table), and then the matched record is read, updated and written back. Its result
// shows on done in the cycle after the write, while the next item may already be
// taken. Reset empties the table through the fill count; no clearing pass is needed.
// The result receiver cannot stall the block.
module order_status_table_unit
    import ost_pkg::*;
#(
    parameter int TABLE_ENTRIES = OST_TABLE_ENTRIES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic [63:0]        order_id,
    input  logic [63:0]        other_id,
    input  logic               is_user_order,
    input  logic [63:0]        symbol_code,
    input  logic               side_in,
    input  logic [30:0]        quantity_in,
    input  logic [31:0]        price_in,
    output logic               done,
    output logic               found,
    output logic               changed,
    output logic               table_full,
    output logic [63:0]        order_id_out,
    output logic [63:0]        symbol_out,
    output logic               side_out,
    output logic [30:0]        quantity_out,
    output logic [31:0]        price_out,
    output logic signed [31:0] filled_out,
    output logic [1:0]         status_out
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_UPDATE = 3'b100
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic             done_reg;
    res_t             res_reg;

    kind_t            kind_reg;
    logic [63:0]      order_id_reg;
    logic [63:0]      other_id_reg;
    logic             user_reg;
    logic [63:0]      symbol_reg;
    logic             side_reg;
    logic [30:0]      qty_reg;
    logic [31:0]      price_reg;
    logic [IDX_W-1:0] sel_idx_reg;
    logic [IDX_W-1:0] sel_idx;

    logic             accept;
    scan_flags_t      scan_flags;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    rec_t             rec_old;
    rec_t             rec_new;
    upd_ctl_t         ctl;
    upd_act_t         act;
    res_t             res;
    logic             in_update;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign in_update = (state_reg == S_UPDATE);

    // An add that misses goes to the first unused entry, just past the fill count.
    always_comb
    begin
        if (scan_flags.hit_a)
        begin
            sel_idx = idx_a;
        end
        else if (kind_reg == KIND_TRADE)
        begin
            sel_idx = idx_b;
        end
        else if (kind_reg == KIND_ADD)
        begin
            sel_idx = count_reg[IDX_W-1:0];
        end
        else
        begin
            sel_idx = idx_a;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_flags.done)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    ost_key_scan #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .key_a   (order_id),
        .key_b   (other_id),
        .count   (count_reg),
        .wr_en   (in_update && act.wr_key),
        .wr_addr (sel_idx_reg),
        .wr_key  (order_id_reg),
        .flags   (scan_flags),
        .idx_a   (idx_a),
        .idx_b   (idx_b)
    );

    ost_record_mem #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_rec (
        .clk     (clk),
        .wr_en   (in_update && act.wr_rec),
        .wr_addr (sel_idx_reg),
        .wr_data (rec_new),
        .rd_addr (sel_idx),
        .rd_data (rec_old)
    );

    assign ctl.kind    = kind_reg;
    assign ctl.is_user = user_reg;
    assign ctl.hit_a   = scan_flags.hit_a;
    assign ctl.hit_b   = scan_flags.hit_b;
    assign ctl.full    = (count_reg == CNT_W'(TABLE_ENTRIES));

    ost_update u_upd (
        .ctl         (ctl),
        .order_id    (order_id_reg),
        .other_id    (other_id_reg),
        .symbol_code (symbol_reg),
        .side_in     (side_reg),
        .quantity_in (qty_reg),
        .price_in    (price_reg),
        .rec_old     (rec_old),
        .rec_new     (rec_new),
        .act         (act),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= in_update;
            if (in_update && act.grow)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= kind_t'(kind);
            order_id_reg <= order_id;
            other_id_reg <= other_id;
            user_reg     <= is_user_order;
            symbol_reg   <= symbol_code;
            side_reg     <= side_in;
            qty_reg      <= quantity_in;
            price_reg    <= price_in;
        end
        if (state_reg == S_SCAN && scan_flags.done)
        begin
            sel_idx_reg <= sel_idx;
        end
        if (in_update)
        begin
            res_reg <= res;
        end
    end

    assign done         = done_reg;
    assign found        = res_reg.found;
    assign changed      = res_reg.changed;
    assign table_full   = res_reg.table_full;
    assign order_id_out = res_reg.order_id;
    assign symbol_out   = res_reg.rec.symbol;
    assign side_out     = res_reg.rec.side;
    assign quantity_out = res_reg.rec.quantity;
    assign price_out    = res_reg.rec.price;
    assign filled_out   = res_reg.rec.filled;
    assign status_out   = res_reg.rec.status;

`ifndef SYNTHESIS
    // A result follows the update cycle and nothing else.
    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_UPDATE)
        else $error("result strobe without an update cycle");

    // The fill count never passes the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    // A dropped add means the table really was full.
    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && table_full) |-> count_reg == CNT_W'(TABLE_ENTRIES))
        else $error("table_full reported with free entries");

    // The key search only finishes while the controller waits for it.
    a_scan_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        scan_flags.done |-> state_reg == S_SCAN)
        else $error("key search finished outside the search state");
`endif

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for order_status_table_unit: directed table, then random traffic.
// Carries its own order book predictor; depends on ost_pkg and the RTL under rtl/core.
module tb
    import ost_pkg::*;
();

    localparam int BOOK_DEPTH   = OST_TABLE_ENTRIES;
    localparam int QUIET_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 80;
    localparam logic [30:0] QTY_MAX   = 31'h7FFF_FFFF;
    localparam logic [31:0] PRICE_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] order_id;
        logic [63:0] other_id;
        logic        is_user;
        logic [63:0] symbol;
        logic        side;
        logic [30:0] quantity;
        logic [31:0] price;
    } order_event_t;

    typedef struct packed {
        order_event_t ev;
        logic         typed;
        res_t         report;
    } directed_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         kind;
    logic [63:0]        order_id;
    logic [63:0]        other_id;
    logic               is_user_order;
    logic [63:0]        symbol_code;
    logic               side_in;
    logic [30:0]        quantity_in;
    logic [31:0]        price_in;
    logic               done;
    logic               found;
    logic               changed;
    logic               table_full;
    logic [63:0]        order_id_out;
    logic [63:0]        symbol_out;
    logic               side_out;
    logic [30:0]        quantity_out;
    logic [31:0]        price_out;
    logic signed [31:0] filled_out;
    logic [1:0]         status_out;

    // Predicted copy of the order book.
    logic        book_valid [BOOK_DEPTH];
    logic [63:0] book_key   [BOOK_DEPTH];
    rec_t        book_rec   [BOOK_DEPTH];
    int          book_count;

    res_t          pending_reports [$];
    res_t          oldest_report;
    directed_row_t directed_rows [$];
    int            mismatches = 0;
    int            quiet_cycles;

    order_status_table_unit dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int lookup_key(logic [63:0] key);
        for (int i = 0; i < BOOK_DEPTH; i++)
        begin
            if (book_valid[i] && book_key[i] == key)
                return i;
        end
        return -1;
    endfunction

    function automatic int first_free_slot();
        for (int i = 0; i < BOOK_DEPTH; i++)
        begin
            if (!book_valid[i])
                return i;
        end
        return -1;
    endfunction

    // Applies one order event to the predicted book and returns the report it produces.
    function automatic res_t apply_order_event(order_event_t ev);
        res_t               rpt;
        int                 idx;
        logic signed [31:0] orig;
        logic signed [31:0] diff;
        rpt = '0;
        case (ev.kind)
            KIND_ADD:
            begin
                if (!ev.is_user)
                    return rpt;
                idx = lookup_key(ev.order_id);
                if (idx < 0)
                    idx = first_free_slot();
                if (idx < 0)
                begin
                    rpt.table_full = 1'b1;
                    return rpt;
                end
                if (!book_valid[idx])
                    book_count++;
                book_valid[idx]        = 1'b1;
                book_key[idx]          = ev.order_id;
                book_rec[idx].symbol   = ev.symbol;
                book_rec[idx].side     = ev.side;
                book_rec[idx].quantity = ev.quantity;
                book_rec[idx].price    = ev.price;
                book_rec[idx].filled   = '0;
                book_rec[idx].status   = ST_NEW;
                rpt.changed = 1'b1;
            end
            KIND_MODIFY:
            begin
                idx = lookup_key(ev.order_id);
                if (idx < 0)
                    return rpt;
                orig = $signed({1'b0, book_rec[idx].quantity});
                diff = orig - $signed({1'b0, ev.quantity});
                if (diff >= orig)
                begin
                    book_rec[idx].filled = orig;
                    book_rec[idx].status = ST_FILLED;
                end
                else
                begin
                    book_rec[idx].filled = diff;
                    book_rec[idx].status = ST_PARTIAL;
                end
                rpt.changed = 1'b1;
            end
            KIND_REMOVE:
            begin
                idx = lookup_key(ev.order_id);
                if (idx < 0)
                    return rpt;
                if (book_rec[idx].status != ST_FILLED && book_rec[idx].status != ST_CANCELLED)
                begin
                    book_rec[idx].status = ST_CANCELLED;
                    rpt.changed = 1'b1;
                end
            end
            default:
            begin
                // The sell-side id wins when both are tracked.
                idx = lookup_key(ev.order_id);
                if (idx < 0)
                    idx = lookup_key(ev.other_id);
                if (idx < 0)
                    return rpt;
            end
        endcase
        rpt.found    = 1'b1;
        rpt.order_id = book_key[idx];
        rpt.rec      = book_rec[idx];
        return rpt;
    endfunction

    function automatic order_event_t make_event(kind_t k, logic [63:0] id, logic [63:0] other,
                                                logic user, logic [63:0] sym, logic sd,
                                                logic [30:0] qty, logic [31:0] px);
        order_event_t ev;
        ev.kind     = k;
        ev.order_id = id;
        ev.other_id = other;
        ev.is_user  = user;
        ev.symbol   = sym;
        ev.side     = sd;
        ev.quantity = qty;
        ev.price    = px;
        return ev;
    endfunction

    function automatic res_t make_report(logic fnd, logic chg, logic full, logic [63:0] id,
                                         logic [63:0] sym, logic sd, logic [30:0] qty,
                                         logic [31:0] px, logic signed [31:0] fill,
                                         status_t st);
        res_t rpt;
        rpt.found        = fnd;
        rpt.changed      = chg;
        rpt.table_full   = full;
        rpt.order_id     = id;
        rpt.rec.symbol   = sym;
        rpt.rec.side     = sd;
        rpt.rec.quantity = qty;
        rpt.rec.price    = px;
        rpt.rec.filled   = fill;
        rpt.rec.status   = st;
        return rpt;
    endfunction

    task automatic add_row(order_event_t ev, logic typed, res_t rpt);
        directed_row_t row;
        row.ev     = ev;
        row.typed  = typed;
        row.report = rpt;
        directed_rows.push_back(row);
    endtask

    // An id already in the book, or with fresh_pct odds a fresh one: a wide random key or one of 0 to 15.
    function automatic logic [63:0] pick_id(int fresh_pct);
        if (book_count > 0 && $urandom_range(0, 99) >= fresh_pct)
            return book_key[$urandom_range(0, book_count - 1)];
        if ($urandom_range(0, 4) == 0)
            return 64'($urandom_range(0, 15));
        return {$urandom, $urandom};
    endfunction

    function automatic order_event_t random_order_event(int add_pct, int fresh_pct);
        order_event_t ev;
        int           r;
        int           idx;
        logic [30:0]  q;
        r = $urandom_range(0, 99);
        if (r < add_pct)
            ev.kind = KIND_ADD;
        else if (r < add_pct + (100 - add_pct) * 4 / 7)
            ev.kind = KIND_MODIFY;
        else if (r < add_pct + (100 - add_pct) * 5 / 7)
            ev.kind = KIND_REMOVE;
        else
            ev.kind = KIND_TRADE;
        ev.order_id = pick_id(ev.kind == KIND_ADD ? fresh_pct : 15);
        ev.other_id = pick_id(30);
        ev.is_user  = ($urandom_range(0, 99) < 85);
        ev.symbol   = {$urandom, $urandom};
        ev.side     = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 19))
            0:       ev.price = '0;
            1:       ev.price = PRICE_MAX;
            default: ev.price = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0:       ev.quantity = '0;
            1:       ev.quantity = QTY_MAX;
            2, 3, 4: ev.quantity = 31'($urandom_range(0, 1000));
            default: ev.quantity = 31'($urandom);
        endcase
        if (ev.kind == KIND_MODIFY)
        begin
            idx = lookup_key(ev.order_id);
            if (idx >= 0)
            begin
                q = book_rec[idx].quantity;
                case ($urandom_range(0, 5))
                    0: ev.quantity = '0;
                    1: ev.quantity = q;
                    2: ev.quantity = (q == 0) ? '0 : 31'($urandom_range(0, q - 1));
                    3: ev.quantity = q + 31'($urandom_range(1, 500));
                    4: ev.quantity = QTY_MAX;
                    default: ;
                endcase
            end
        end
        return ev;
    endfunction

    // Presents one event and returns at the edge where it is transferred.
    task automatic send_order_event(order_event_t ev);
        kind          <= ev.kind;
        order_id      <= ev.order_id;
        other_id      <= ev.other_id;
        is_user_order <= ev.is_user;
        symbol_code   <= ev.symbol;
        side_in       <= ev.side;
        quantity_in   <= ev.quantity;
        price_in      <= ev.price;
        start         <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic sender_gap(int idle_pct);
        int n;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 90) : $urandom_range(1, 4);
            start       <= 1'b0;
            kind        <= 2'($urandom_range(0, 3));
            order_id    <= {$urandom, $urandom};
            quantity_in <= 31'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_reports();
        start <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: result with none expected, expected none, got id %h",
                         $time, order_id_out);
                mismatches++;
            end
            else
            begin
                oldest_report = pending_reports.pop_front();
                compare_field("found", oldest_report.found, found);
                compare_field("changed", oldest_report.changed, changed);
                compare_field("table_full", oldest_report.table_full, table_full);
                compare_field("order_id_out", oldest_report.order_id, order_id_out);
                compare_field("symbol_out", oldest_report.rec.symbol, symbol_out);
                compare_field("side_out", oldest_report.rec.side, side_out);
                compare_field("quantity_out", oldest_report.rec.quantity, quantity_out);
                compare_field("price_out", oldest_report.rec.price, price_out);
                compare_field("filled_out", oldest_report.rec.filled, filled_out);
                compare_field("status_out", oldest_report.rec.status, status_out);
            end
        end
    end

    // Watchdog: any stretch without a transfer on either side is bounded.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int           phase_items [4];
        int           phase_idle  [4];
        int           phase_add   [4];
        int           phase_fresh [4];
        int           count;
        order_event_t ev;
        res_t         zero_rpt;
        res_t         model_rpt;

        phase_items = '{300, 300, 300, 200};
        phase_idle  = '{0, 47, 35, 0};
        phase_add   = '{45, 30, 30, 30};
        phase_fresh = '{60, 15, 15, 15};

        rst_n         <= 1'b0;
        start         <= 1'b0;
        kind          <= '0;
        order_id      <= '0;
        other_id      <= '0;
        is_user_order <= 1'b0;
        symbol_code   <= '0;
        side_in       <= 1'b0;
        quantity_in   <= '0;
        price_in      <= '0;
        book_count    = 0;
        for (int i = 0; i < BOOK_DEPTH; i++)
            book_valid[i] = 1'b0;

        zero_rpt = '0;
        // Lookups on an empty book, then a non-user add.
        add_row(make_event(KIND_TRADE, '0, '0, 1'b1, '0, 1'b0, '0, '0), 1'b1, zero_rpt);
        add_row(make_event(KIND_MODIFY, '1, '0, 1'b1, '1, 1'b1, QTY_MAX, PRICE_MAX), 1'b1,
                zero_rpt);
        add_row(make_event(KIND_REMOVE, '0, '1, 1'b0, '0, 1'b0, '0, '0), 1'b1, zero_rpt);
        add_row(make_event(KIND_ADD, 64'd7, '0, 1'b0, '1, 1'b1, QTY_MAX, PRICE_MAX), 1'b1,
                zero_rpt);
        // Field extremes.
        add_row(make_event(KIND_ADD, '1, '0, 1'b1, '1, 1'b1, QTY_MAX, PRICE_MAX), 1'b1,
                make_report(1'b1, 1'b1, 1'b0, '1, '1, 1'b1, QTY_MAX, PRICE_MAX, '0, ST_NEW));
        add_row(make_event(KIND_ADD, '0, '1, 1'b1, '0, 1'b0, '0, '0), 1'b1,
                make_report(1'b1, 1'b1, 1'b0, '0, '0, 1'b0, '0, '0, '0, ST_NEW));
        add_row(make_event(KIND_MODIFY, '1, '0, 1'b1, '0, 1'b0, '0, '0), 1'b1,
                make_report(1'b1, 1'b1, 1'b0, '1, '1, 1'b1, QTY_MAX, PRICE_MAX,
                            32'sh7FFF_FFFF, ST_FILLED));
        // Removing a filled order leaves it untouched.
        add_row(make_event(KIND_REMOVE, '1, '0, 1'b0, '0, 1'b0, '0, '0), 1'b1,
                make_report(1'b1, 1'b0, 1'b0, '1, '1, 1'b1, QTY_MAX, PRICE_MAX,
                            32'sh7FFF_FFFF, ST_FILLED));
        // Remaining above original gives the most negative filled amount.
        add_row(make_event(KIND_MODIFY, '0, '0, 1'b1, '0, 1'b0, QTY_MAX, '0), 1'b1,
                make_report(1'b1, 1'b1, 1'b0, '0, '0, 1'b0, '0, '0, 32'sh8000_0001,
                            ST_PARTIAL));
        add_row(make_event(KIND_REMOVE, '0, '0, 1'b1, '0, 1'b0, '0, '0), 1'b1,
                make_report(1'b1, 1'b1, 1'b0, '0, '0, 1'b0, '0, '0, 32'sh8000_0001,
                            ST_CANCELLED));
        add_row(make_event(KIND_REMOVE, '0, '0, 1'b1, '0, 1'b0, '0, '0), 1'b1,
                make_report(1'b1, 1'b0, 1'b0, '0, '0, 1'b0, '0, '0, 32'sh8000_0001,
                            ST_CANCELLED));
        // Trade lookups: buy side fallback, sell side priority, neither known.
        add_row(make_event(KIND_TRADE, 64'd5, '0, 1'b0, '0, 1'b0, '0, '0), 1'b0, zero_rpt);
        add_row(make_event(KIND_TRADE, '1, '0, 1'b0, '0, 1'b0, '0, '0), 1'b0, zero_rpt);
        add_row(make_event(KIND_TRADE, 64'd5, 64'd6, 1'b1, '0, 1'b0, '0, '0), 1'b1,
                zero_rpt);
        // Overwrite of an existing key, then a series of modifies on it.
        add_row(make_event(KIND_ADD, '0, '0, 1'b1, 64'hA5A5_5A5A_0F0F_F0F0, 1'b1, 31'd100,
                           32'd1234), 1'b0, zero_rpt);
        add_row(make_event(KIND_MODIFY, '0, '0, 1'b1, '0, 1'b0, 31'd40, '0), 1'b0, zero_rpt);
        add_row(make_event(KIND_MODIFY, '0, '0, 1'b1, '0, 1'b0, 31'd100, '0), 1'b0, zero_rpt);
        add_row(make_event(KIND_MODIFY, '0, '0, 1'b1, '0, 1'b0, 31'd0, '0), 1'b0, zero_rpt);
        add_row(make_event(KIND_ADD, 64'h8000_0000_0000_0000, '0, 1'b1, 64'd1, 1'b0, '0,
                           32'd9), 1'b0, zero_rpt);
        add_row(make_event(KIND_MODIFY, 64'h8000_0000_0000_0000, '0, 1'b1, '0, 1'b0, '0, '0),
                1'b0, zero_rpt);
        // A non-user add of a tracked key writes nothing.
        add_row(make_event(KIND_ADD, '1, '0, 1'b0, '0, 1'b0, '0, '0), 1'b1, zero_rpt);
        add_row(make_event(KIND_ADD, 64'd3, '0, 1'b1, 64'h4142_4344, 1'b1, 31'd200, 32'd77),
                1'b0, zero_rpt);
        add_row(make_event(KIND_REMOVE, 64'd3, '0, 1'b1, '0, 1'b0, '0, '0), 1'b0, zero_rpt);
        add_row(make_event(KIND_MODIFY, 64'd3, '0, 1'b1, '0, 1'b0, 31'd500, '0), 1'b0,
                zero_rpt);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_order_event(directed_rows[i].ev);
            model_rpt = apply_order_event(directed_rows[i].ev);
            pending_reports.push_back(directed_rows[i].typed ? directed_rows[i].report
                                                             : model_rpt);
        end
        drain_reports();

        // The first phase adds many fresh keys so the book fills up step by step.
        for (int p = 0; p < 4; p++)
        begin
            count = 0;
            while (count < phase_items[p])
            begin
                ev = random_order_event(phase_add[p], phase_fresh[p]);
                sender_gap(phase_idle[p]);
                send_order_event(ev);
                pending_reports.push_back(apply_order_event(ev));
                if (!(ev.kind == KIND_ADD && !ev.is_user))
                    count++;
            end
            drain_reports();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[order_status_table_unit.f]
rtl/core/ost_pkg.sv
rtl/core/ost_key_scan.sv
rtl/core/ost_record_mem.sv
rtl/core/ost_update.sv
rtl/core/order_status_table_unit.sv
sim/tb.sv
